### sv/ppm_pkg.sv
`timescale 1ns / 1ps

package ppm_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_VARIANT   = 2'd0;
    localparam logic [1:0] ERR_HEADER    = 2'd1;
    localparam logic [1:0] ERR_DIMENSION = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_3     = 8'h33;
    localparam logic [7:0] CHAR_6     = 8'h36;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  max_value;
        logic        is_binary;
        logic [7:0]  sample;
        logic [1:0]  error_code;
        logic        image_done;
    } t_out_item;

    // work handed from parser to scaler: raw value to scale, or a ready result
    typedef struct packed {
        logic       scale;
        logic       saturate;
        logic [9:0] value;
        t_out_item  res;
    } t_job;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

### sv/ppm_stream_decoder.sv
`timescale 1ns / 1ps
// path: a sample beat passes the parser slot, the one-entry queue and an 18-step
//   restoring divider before it is offered; header and error beats skip the divider
// flow: the scaler takes no new job until the last is taken; other bytes are taken
//   one a cycle while the parser neither holds a job nor loads its sample count, and a
//   byte that makes a beat holds off the next byte until its job has left the parser slot
// reset: synchronous active-low i_rst_n returns parser, queue and divider to idle
module ppm_stream_decoder #(
    parameter int DIM_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ppm_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output ppm_pkg::t_out_item o_item
);

    logic p_valid, p_ready;
    ppm_pkg::t_job p_job;
    logic r_q_valid;
    ppm_pkg::t_job r_q_job;
    logic [7:0] r_mv;
    logic s_ready;

    ppm_parse #(.DIM_BITS(DIM_BITS)) u_parse (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item,
        .o_job_valid(p_valid), .i_job_ready(p_ready), .o_job(p_job)
    );

    // one-entry queue; maxval is latched from the header beat
    assign p_ready = !r_q_valid || s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q_valid <= 1'b0;
        else if (p_ready) r_q_valid <= p_valid;
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && p_valid) r_q_job <= p_job;
        if (p_ready && p_valid && p_job.res.kind == ppm_pkg::KIND_HEADER)
            r_mv <= p_job.res.max_value;
    end

    ppm_scale u_scale (
        .i_clk, .i_rst_n, .i_valid(r_q_valid), .o_ready(s_ready), .i_job(r_q_job),
        .i_maxval(r_mv), .o_valid, .i_ready, .o_item
    );

endmodule

### sv/ppm_parse.sv
`timescale 1ns / 1ps

module ppm_parse #(
    parameter int DIM_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ppm_pkg::t_in_item i_item,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output ppm_pkg::t_job     o_job
);

    localparam int AccW = DIM_BITS + 2;
    localparam logic [AccW-1:0] AccMax = '1;
    localparam int CntW = 2 * DIM_BITS + 2;

    typedef enum logic [7:0] {
        PH_MAGIC  = 8'b0000_0001,
        PH_WIDTH  = 8'b0000_0010,
        PH_HEIGHT = 8'b0000_0100,
        PH_MAXVAL = 8'b0000_1000,
        PH_P3DATA = 8'b0001_0000,
        PH_P6SKIP = 8'b0010_0000,
        PH_P6DATA = 8'b0100_0000,
        PH_DRAIN  = 8'b1000_0000
    } t_phase;

    t_phase r_phase, n_phase;
    logic [AccW-1:0] r_acc, n_acc;
    logic r_has_digit, n_has_digit, r_active, n_active, r_invalid, n_invalid;
    logic r_comment, n_comment, r_bin, n_bin;
    logic [1:0] r_mpos, n_mpos;
    logic [DIM_BITS-1:0] r_w, n_w, r_h, n_h;
    logic [7:0] r_mv, n_mv;
    // width or height was zero or too wide
    logic r_dim_bad, n_dim_bad;
    logic [CntW-1:0] r_left, n_left;
    // sample count width*height*3 loaded in a wait cycle after maxval
    logic r_mul, n_mul;

    // up to two jobs produced from one byte; second held in a pending slot
    ppm_pkg::t_job r_pend, n_pend;
    logic r_pend_v, n_pend_v;
    ppm_pkg::t_job j0, j1;
    logic j0v, j1v;

    logic [7:0] c;
    logic eof, ws, dig, take;
    logic [AccW+3:0] prod10;

    assign c   = i_item.byte_value;
    assign eof = i_item.end_of_file;
    assign ws  = ppm_pkg::is_ws(c);
    assign dig = (c >= ppm_pkg::CHAR_0) && (c <= ppm_pkg::CHAR_9);

    assign o_ready = !r_pend_v && !r_mul && (!o_job_valid || i_job_ready) ? 1'b1 : 1'b0;
    assign take = i_valid && o_ready;

    always_comb begin
        o_job_valid = r_pend_v;
        o_job = r_pend;
    end

    function automatic ppm_pkg::t_job err_job(input logic [1:0] code);
        ppm_pkg::t_job j;
        j = '0;
        j.res.kind = ppm_pkg::KIND_ERROR;
        j.res.error_code = code;
        j.res.image_done = 1'b1;
        return j;
    endfunction

    always_comb begin
        logic [AccW-1:0] acc;
        logic has, mok, fin, bad;
        logic [1:0] cnt;
        ppm_pkg::t_job jj [2];
        ppm_pkg::t_job js;
        n_phase = r_phase; n_acc = r_acc; n_has_digit = r_has_digit;
        n_active = r_active; n_invalid = r_invalid; n_comment = r_comment;
        n_bin = r_bin; n_mpos = r_mpos; n_w = r_w; n_h = r_h; n_mv = r_mv;
        n_dim_bad = r_dim_bad;
        n_left = r_left; n_mul = 1'b0;
        n_pend = r_pend; n_pend_v = r_pend_v && !i_job_ready;
        cnt = 2'd0; jj[0] = '0; jj[1] = '0;
        acc = '0; has = 1'b0; mok = 1'b0; fin = 1'b0; bad = 1'b0; js = '0;
        j0 = '0; j1 = '0; j0v = 1'b0; j1v = 1'b0;
        prod10 = '0;
        if (r_mul) begin
            n_left = CntW'(r_w) * CntW'(r_h) * CntW'(3);
        end else if (take) begin
            // byte handling
            if (r_phase == PH_MAGIC || r_phase == PH_WIDTH || r_phase == PH_HEIGHT ||
                r_phase == PH_MAXVAL || r_phase == PH_P3DATA) begin
                if (r_comment) begin
                    if (c == ppm_pkg::CHAR_LF) n_comment = 1'b0;
                end else if (!r_active && c == ppm_pkg::CHAR_HASH) begin
                    n_comment = 1'b1;
                end else if (!r_active && ws) begin
                end else if (r_active && ws) begin
                    fin = 1'b1;
                end else begin
                    n_active = 1'b1;
                    if (r_phase == PH_MAGIC) begin
                        if (r_mpos == 2'd0) begin
                            if (c != ppm_pkg::CHAR_P) n_invalid = 1'b1;
                        end else if (r_mpos == 2'd1) begin
                            if (c == ppm_pkg::CHAR_3) n_bin = 1'b0;
                            else if (c == ppm_pkg::CHAR_6) n_bin = 1'b1;
                            else n_invalid = 1'b1;
                        end else n_invalid = 1'b1;
                        if (r_mpos != 2'd2) n_mpos = r_mpos + 2'd1;
                    end else if (!r_invalid) begin
                        if (dig) begin
                            prod10 = (AccW+4)'(r_acc) * (AccW+4)'(10)
                                     + (AccW+4)'(c - ppm_pkg::CHAR_0);
                            n_acc = (prod10 > (AccW+4)'(AccMax)) ? AccMax
                                    : prod10[AccW-1:0];
                            n_has_digit = 1'b1;
                        end else n_invalid = 1'b1;
                    end
                end
            end else if (r_phase == PH_P6SKIP || r_phase == PH_P6DATA) begin
                if (r_phase == PH_P6DATA || !ws) begin
                    n_phase = PH_P6DATA;
                    js = '0;
                    js.scale = 1'b1;
                    js.value = {2'b00, c};
                    js.res.kind = ppm_pkg::KIND_SAMPLE;
                    js.res.is_binary = 1'b1;
                    if (r_left == CntW'(1) || r_left == '0) begin
                        js.res.image_done = 1'b1;
                        n_phase = PH_DRAIN;
                    end
                    n_left = (r_left != '0) ? r_left - CntW'(1) : r_left;
                    jj[cnt[0]] = js; cnt = cnt + 2'd1;
                end
            end
            // end of token at end of file
            if (eof && n_active && !fin && n_phase == r_phase &&
                (r_phase == PH_MAGIC || r_phase == PH_WIDTH || r_phase == PH_HEIGHT ||
                 r_phase == PH_MAXVAL || r_phase == PH_P3DATA))
                fin = 1'b1;
            if (fin) begin
                acc = n_acc; has = n_has_digit;
                mok = (n_mpos == 2'd2) && !n_invalid;
                bad = (acc[AccW-1 -: 2] != 2'b00) || (acc == '0);
                n_acc = '0; n_has_digit = 1'b0; n_active = 1'b0;
                n_invalid = 1'b0; n_mpos = 2'd0;
                case (r_phase)
                    PH_MAGIC: begin
                        if (!mok) begin
                            jj[cnt[0]] = err_job(ppm_pkg::ERR_VARIANT); cnt = cnt + 2'd1;
                            n_phase = PH_DRAIN;
                        end else n_phase = PH_WIDTH;
                    end
                    PH_WIDTH, PH_HEIGHT: begin
                        if (!has) begin
                            jj[cnt[0]] = err_job(ppm_pkg::ERR_HEADER); cnt = cnt + 2'd1;
                            n_phase = PH_DRAIN;
                        end else if (r_phase == PH_WIDTH) begin
                            n_w = acc[DIM_BITS-1:0];
                            n_dim_bad = bad;
                            n_phase = PH_HEIGHT;
                        end else begin
                            n_h = acc[DIM_BITS-1:0];
                            n_dim_bad = r_dim_bad || bad;
                            n_phase = PH_MAXVAL;
                        end
                    end
                    PH_MAXVAL: begin
                        if (!has) begin
                            jj[cnt[0]] = err_job(ppm_pkg::ERR_HEADER); cnt = cnt + 2'd1;
                            n_phase = PH_DRAIN;
                        end else if (r_dim_bad || acc == '0 || acc > AccW'(255)) begin
                            jj[cnt[0]] = err_job(ppm_pkg::ERR_DIMENSION);
                            cnt = cnt + 2'd1;
                            n_phase = PH_DRAIN;
                        end else begin
                            n_mv = acc[7:0];
                            n_mul = 1'b1;
                            n_phase = r_bin ? PH_P6SKIP : PH_P3DATA;
                            js = '0;
                            js.res.kind = ppm_pkg::KIND_HEADER;
                            js.res.image_width = 16'(r_w);
                            js.res.image_height = 16'(r_h);
                            js.res.max_value = acc[7:0];
                            js.res.is_binary = r_bin;
                            jj[cnt[0]] = js; cnt = cnt + 2'd1;
                        end
                    end
                    PH_P3DATA: begin
                        if (!has) begin
                            jj[cnt[0]] = err_job(ppm_pkg::ERR_TRUNCATED);
                            cnt = cnt + 2'd1;
                            n_phase = PH_DRAIN;
                        end else begin
                            js = '0;
                            js.scale = 1'b1;
                            js.saturate = 1'b1;
                            js.value = (acc > AccW'(1023)) ? 10'd1023 : acc[9:0];
                            js.res.kind = ppm_pkg::KIND_SAMPLE;
                            if (r_left == CntW'(1) || r_left == '0) begin
                                js.res.image_done = 1'b1;
                                n_phase = PH_DRAIN;
                            end
                            n_left = (r_left != '0) ? r_left - CntW'(1) : r_left;
                            jj[cnt[0]] = js; cnt = cnt + 2'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (eof) begin
                case (n_phase)
                    PH_MAGIC: begin
                        jj[cnt[0]] = err_job(ppm_pkg::ERR_VARIANT); cnt = cnt + 2'd1;
                    end
                    PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
                        jj[cnt[0]] = err_job(ppm_pkg::ERR_HEADER); cnt = cnt + 2'd1;
                    end
                    PH_DRAIN: ;
                    default: begin
                        jj[cnt[0]] = err_job(ppm_pkg::ERR_TRUNCATED); cnt = cnt + 2'd1;
                    end
                endcase
                n_phase = PH_MAGIC; n_acc = '0; n_has_digit = 1'b0; n_active = 1'b0;
                n_invalid = 1'b0; n_comment = 1'b0; n_mpos = 2'd0; n_bin = 1'b0;
                n_w = '0; n_h = '0; n_mv = '0; n_dim_bad = 1'b0; n_left = '0;
                n_mul = 1'b0;
            end
            j0 = jj[0]; j1 = jj[1];
            j0v = cnt != 2'd0; j1v = cnt == 2'd2;
            if (j0v) begin
                n_pend = j0;
                n_pend_v = 1'b1;
            end
        end
    end

    // second job of a byte waits here, blocking input until it goes out
    ppm_pkg::t_job r_second;
    logic r_second_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC; r_acc <= '0; r_has_digit <= 1'b0; r_active <= 1'b0;
            r_invalid <= 1'b0; r_comment <= 1'b0; r_bin <= 1'b0; r_mpos <= 2'd0;
            r_w <= '0; r_h <= '0; r_mv <= '0; r_dim_bad <= 1'b0; r_left <= '0;
            r_mul <= 1'b0;
            r_pend_v <= 1'b0; r_second_v <= 1'b0;
        end else begin
            r_phase <= n_phase; r_acc <= n_acc; r_has_digit <= n_has_digit;
            r_active <= n_active; r_invalid <= n_invalid; r_comment <= n_comment;
            r_bin <= n_bin; r_mpos <= n_mpos; r_w <= n_w; r_h <= n_h; r_mv <= n_mv;
            r_dim_bad <= n_dim_bad;
            r_left <= n_left; r_mul <= n_mul;
            if (r_second_v && (!r_pend_v || i_job_ready)) begin
                r_pend_v <= 1'b1;
                r_second_v <= 1'b0;
            end else begin
                r_pend_v <= n_pend_v;
                if (j1v) r_second_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_second_v && (!r_pend_v || i_job_ready)) r_pend <= r_second;
        else r_pend <= n_pend;
        if (j1v) r_second <= j1;
    end

endmodule

### sv/ppm_scale.sv
`timescale 1ns / 1ps

// value*255/maxval by restoring division, one quotient bit per cycle; jobs that need no scaling pass straight through
module ppm_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ppm_pkg::t_job      i_job,
    input  logic [7:0]         i_maxval,
    output logic               o_valid,
    input  logic               i_ready,
    output ppm_pkg::t_out_item o_item
);

    localparam int NumW = 18;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state r_state;
    ppm_pkg::t_job r_job;
    logic [NumW-1:0] r_num, r_quo;
    logic [8:0] r_rem;
    logic [4:0] r_bit;
    logic [7:0] r_mv;
    logic [9:0] rem_sh;
    logic [NumW-1:0] q;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign rem_sh = {r_rem, r_num[NumW-1]};

    always_comb begin
        o_item = r_job.res;
        q = r_quo;
        if (r_job.scale) begin
            if (r_job.saturate) o_item.sample = (q > NumW'(255)) ? 8'd255 : q[7:0];
            else o_item.sample = q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_job <= i_job;
                        r_mv <= i_maxval;
                        r_num <= NumW'(i_job.value) * NumW'(ppm_pkg::FULL_SCALE);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_bit <= 5'(NumW);
                        if (!i_job.scale) r_state <= ST_OUT;
                        else if (i_maxval == '0) begin
                            r_quo <= i_job.saturate ? NumW'(255) : NumW'(i_job.value);
                            r_state <= ST_OUT;
                        end else r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_num <= {r_num[NumW-2:0], 1'b0};
                    if (rem_sh >= {2'b00, r_mv}) begin
                        r_rem <= 9'(rem_sh - {2'b00, r_mv});
                        r_quo <= {r_quo[NumW-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[8:0];
                        r_quo <= {r_quo[NumW-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd1) r_state <= ST_OUT;
                end
                ST_OUT: if (i_ready) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### dv/ppm_stream_decoder_test.sv
`timescale 1ns / 1ps

module ppm_stream_decoder_test;

    localparam int DIM_BITS  = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 60;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_P3DATA, PH_P6SKIP, PH_P6DATA, PH_DRAIN
    } t_phase;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    ppm_pkg::t_in_item   i_item;
    logic                o_valid;
    logic                i_ready;
    ppm_pkg::t_out_item  o_item;

    ppm_stream_decoder #(.DIM_BITS(DIM_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    // decoder shadow state
    t_phase      ph;
    logic [17:0] acc;
    logic        has_digit, tok_active, tok_bad, in_comment, binary;
    logic [1:0]  magic_pos;
    logic [23:0] width_r, height_r;
    logic [7:0]  maxval_r;
    longint      left_cnt;

    ppm_pkg::t_in_item  byte_queue[$];
    ppm_pkg::t_out_item expected_results[$];
    int        mismatches, results_seen, bytes_sent, headers_seen, errors_seen;
    int        idle_cycles;
    bit        hold_sender;

    function automatic ppm_pkg::t_out_item blank();
        ppm_pkg::t_out_item r;
        r = '0;
        return r;
    endfunction

    function automatic bit ws(input logic [7:0] c);
        return c == ppm_pkg::CHAR_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    task automatic shadow_reset();
        ph = PH_MAGIC; acc = 0; has_digit = 0; tok_active = 0; tok_bad = 0;
        in_comment = 0; magic_pos = 0; binary = 0; width_r = 0; height_r = 0;
        maxval_r = 0; left_cnt = 0;
    endtask

    task automatic expect_beat(input ppm_pkg::t_out_item r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic push_error(input logic [1:0] code);
        ppm_pkg::t_out_item r;
        r = blank();
        r.kind = ppm_pkg::KIND_ERROR; r.error_code = code; r.image_done = 1'b1;
        ph = PH_DRAIN;
        expect_beat(r);
    endtask

    task automatic push_sample(input logic [7:0] v);
        ppm_pkg::t_out_item r;
        if (left_cnt > 0) left_cnt--;
        if (left_cnt == 0) ph = PH_DRAIN;
        r = blank();
        r.kind = ppm_pkg::KIND_SAMPLE; r.is_binary = binary; r.sample = v;
        r.image_done = (left_cnt == 0);
        expect_beat(r);
    endtask

    task automatic feed(input logic [7:0] c);
        longint v;
        if (ph == PH_MAGIC) begin
            if (magic_pos == 0) begin
                if (c != ppm_pkg::CHAR_P) tok_bad = 1;
            end else if (magic_pos == 1) begin
                if (c == ppm_pkg::CHAR_3) binary = 0;
                else if (c == ppm_pkg::CHAR_6) binary = 1;
                else tok_bad = 1;
            end else tok_bad = 1;
            if (magic_pos < 2) magic_pos++;
            return;
        end
        if (tok_bad) return;
        if (c >= ppm_pkg::CHAR_0 && c <= ppm_pkg::CHAR_9) begin
            v = longint'(acc) * 10 + longint'(c - ppm_pkg::CHAR_0);
            acc = v > 18'h3ffff ? 18'h3ffff : v[17:0];
            has_digit = 1;
        end else tok_bad = 1;
    endtask

    task automatic close_token();
        logic [17:0] a;
        bit ok, magic_ok;
        longint v;
        ppm_pkg::t_out_item r;
        a = acc; ok = has_digit; magic_ok = (magic_pos == 2) && !tok_bad;
        acc = 0; has_digit = 0; tok_active = 0; tok_bad = 0; magic_pos = 0;
        case (ph)
            PH_MAGIC: begin
                if (!magic_ok) push_error(ppm_pkg::ERR_VARIANT);
                else ph = PH_WIDTH;
            end
            PH_WIDTH: begin
                if (!ok) push_error(ppm_pkg::ERR_HEADER);
                else begin width_r = 24'(a); ph = PH_HEIGHT; end
            end
            PH_HEIGHT: begin
                if (!ok) push_error(ppm_pkg::ERR_HEADER);
                else begin height_r = 24'(a); ph = PH_MAXVAL; end
            end
            PH_MAXVAL: begin
                if (!ok) push_error(ppm_pkg::ERR_HEADER);
                else if (width_r == 0 || height_r == 0 || a == 0 || a > 255
                         || width_r >= (1 << DIM_BITS) || height_r >= (1 << DIM_BITS))
                    push_error(ppm_pkg::ERR_DIMENSION);
                else begin
                    maxval_r = a[7:0];
                    left_cnt = longint'(width_r) * longint'(height_r) * 3;
                    ph = binary ? PH_P6SKIP : PH_P3DATA;
                    r = blank();
                    r.kind = ppm_pkg::KIND_HEADER; r.image_width = width_r[15:0];
                    r.image_height = height_r[15:0]; r.max_value = maxval_r;
                    r.is_binary = binary;
                    headers_seen++;
                    expect_beat(r);
                end
            end
            PH_P3DATA: begin
                if (!ok) push_error(ppm_pkg::ERR_TRUNCATED);
                else begin
                    v = (longint'(a) * 255) / longint'(maxval_r);
                    push_sample(v > 255 ? 8'd255 : v[7:0]);
                end
            end
            default: ;
        endcase
    endtask

    task automatic decode_byte(input ppm_pkg::t_in_item it);
        logic [7:0] c;
        longint v;
        c = it.byte_value;
        if (ph <= PH_P3DATA) begin
            if (in_comment) begin
                if (c == ppm_pkg::CHAR_LF) in_comment = 0;
            end else if (!tok_active) begin
                if (c == ppm_pkg::CHAR_HASH) in_comment = 1;
                else if (!ws(c)) begin
                    tok_active = 1;
                    feed(c);
                end
            end else if (ws(c)) close_token();
            else feed(c);
        end else if (ph == PH_P6SKIP || ph == PH_P6DATA) begin
            if (ph == PH_P6SKIP && !ws(c)) ph = PH_P6DATA;
            if (ph == PH_P6DATA) begin
                v = (longint'(c) * 255) / longint'(maxval_r);
                push_sample(v[7:0]);
            end
        end
        if (it.end_of_file) begin
            if (ph <= PH_P3DATA && tok_active) close_token();
            if (ph == PH_MAGIC) push_error(ppm_pkg::ERR_VARIANT);
            else if (ph <= PH_MAXVAL) push_error(ppm_pkg::ERR_HEADER);
            else if (ph != PH_DRAIN) push_error(ppm_pkg::ERR_TRUNCATED);
            shadow_reset();
        end
    endtask

    task automatic report(input string what, input ppm_pkg::t_out_item got,
                          input ppm_pkg::t_out_item want);
        mismatches++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    // stimulus builders
    task automatic put(input logic [7:0] c, input bit eof = 0);
        ppm_pkg::t_in_item it;
        it.byte_value = c; it.end_of_file = eof;
        byte_queue.insert(byte_queue.size(), it);
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put(s[k]);
    endtask

    task automatic put_sep();
        int n;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 7))
                0: put(8'd9);
                1: put(8'd13);
                2: put_text("#c x\n");
                default: put(($urandom_range(0, 1)) ? ppm_pkg::CHAR_SPACE : ppm_pkg::CHAR_LF);
            endcase
        end
    endtask

    task automatic put_file();
        bit p6;
        int w, h, mv, n, mode;
        p6 = $urandom_range(0, 1);
        w = $urandom_range(1, 3); h = $urandom_range(1, 2);
        mv = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255);
        mode = $urandom_range(0, 9);
        if (mode == 0) put_text(p6 ? "P7" : "Q3");
        else put_text(p6 ? "P6" : "P3");
        put_sep();
        if (mode == 1) put_text("-2"); else put_text($sformatf("%0d", w));
        put_sep();
        if (mode == 2) put_text("0"); else put_text($sformatf("%0d", h));
        put_sep();
        if (mode == 3) put_text("300"); else put_text($sformatf("%0d", mv));
        n = w * h * 3;
        if (mode == 4) n = $urandom_range(0, n - 1);
        if (p6) begin
            put(ppm_pkg::CHAR_LF);
            for (int k = 0; k < n; k++) put(8'($urandom_range(0, 255)));
        end else begin
            for (int k = 0; k < n; k++) begin
                put_sep();
                put_text($sformatf("%0d", $urandom_range(0, 3) == 0 ?
                                   $urandom_range(0, 999) : $urandom_range(0, mv)));
                if ($urandom_range(0, 15) == 0) put_text("z");
            end
        end
        if ($urandom_range(0, 3) == 0) put_text("junk");
        put(8'h0a, 1);
    endtask

    // clock and reset
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
    end

    // driver: bursts and gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0; i_item <= '0; burst_left <= 0; gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid && o_ready) begin
                decode_byte(i_item);
                bytes_sent++;
            end
            if (gap_left > 0 || hold_sender || byte_queue.size() == 0) begin
                i_valid <= 0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                i_valid <= 1;
                i_item <= byte_queue.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else burst_left <= burst_left - 1;
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase;
    always @(posedge i_clk) begin
        ppm_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 0; stall_phase <= 0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (o_item.kind == ppm_pkg::KIND_ERROR) errors_seen++;
                if (expected_results.size() == 0) report("unexpected beat", o_item, '0);
                else begin
                    want = expected_results.pop_front();
                    if (o_item.kind != want.kind) report("kind", o_item, want);
                    else if (o_item.image_width != want.image_width)
                        report("image_width", o_item, want);
                    else if (o_item.image_height != want.image_height)
                        report("image_height", o_item, want);
                    else if (o_item.max_value != want.max_value)
                        report("max_value", o_item, want);
                    else if (o_item.is_binary != want.is_binary)
                        report("is_binary", o_item, want);
                    else if (o_item.sample != want.sample) report("sample", o_item, want);
                    else if (o_item.error_code != want.error_code)
                        report("error_code", o_item, want);
                    else if (o_item.image_done != want.image_done)
                        report("image_done", o_item, want);
                end
            end
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 16) i_ready <= 1;
            else if (stall_phase < 24) i_ready <= (stall_phase % 3) != 0;
            else i_ready <= $urandom_range(0, 3) != 0;
        end
    end

    // watchdog on beats
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("ppm_stream_decoder_test: errors");
            $finish;
        end
    end

    initial begin
        shadow_reset();
        // directed files
        put_text("P3 2 1 255\n0 255 128 # c\n9 1 255z"); put(ppm_pkg::CHAR_LF, 1);
        put_text("P6 1 1 3\n"); put(8'h00); put(8'hff); put(8'h03, 1);
        put_text("P5 1"); put(ppm_pkg::CHAR_LF, 1);
        put_text("P3 99999999 1 255"); put(ppm_pkg::CHAR_LF, 1);
        put_text("P3 1 1 +4"); put(ppm_pkg::CHAR_LF, 1);
        put_text("P3 1 1 25"); put("5", 1);
        put_text("P3 1 1 5 9 "); put("a", 1);
        put(ppm_pkg::CHAR_SPACE, 1);
        put("P", 1);
        put_text("#x"); put(8'h80, 1);
        wait (byte_queue.size() == 0 && i_rst_n);
        // pause until every expected result has drained
        hold_sender = 1;
        wait (!i_valid && expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        hold_sender = 0;
        while (bytes_sent < 800) begin
            put_file();
            wait (byte_queue.size() < 50);
        end
        wait (byte_queue.size() == 0 && !i_valid && expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("sent %0d bytes; checked %0d results (%0d headers, %0d errors)",
                 bytes_sent, results_seen, headers_seen, errors_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ppm_stream_decoder_test: clean");
        else
            $display("ppm_stream_decoder_test: errors");
        $finish;
    end
endmodule
